[rtl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, suspended while reset is high.
`define SFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define SFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/sfc_pkg.sv]
// ----------------------------------------------------------------------------
// Sphere frustum cull package
// Widths, item and control types shared by the cull test modules.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ELEM_W      = 32;
  localparam int RAD_W       = 31;
  localparam int IDX_W       = 4;
  localparam int MAT_DEPTH   = 16;
  localparam int COEF_W      = ELEM_W + 1;
  localparam int NSUM_W      = 2 * COEF_W;
  localparam int S_W         = 2 * ELEM_W + 4;
  localparam int MAG_W       = S_W;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int R2_W        = 2 * RAD_W;
  localparam int MUL_STEPS   = MAG_W;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
  localparam int PLANE_COUNT = 6;
  localparam int PLANE_W     = 3;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = 1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TEST  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         elem_index;
    logic signed [ELEM_W-1:0] elem_value;
    logic signed [ELEM_W-1:0] center_x;
    logic signed [ELEM_W-1:0] center_y;
    logic signed [ELEM_W-1:0] center_z;
    logic [RAD_W-1:0]         radius;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_PLANE,
    ST_SEND
  } back_state_t;

  typedef enum logic [3:0] {
    STEP_R2,
    STEP_AA,
    STEP_BB,
    STEP_CC,
    STEP_AX,
    STEP_BY,
    STEP_CZ,
    STEP_SS,
    STEP_RN
  } step_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
  } mul_req_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [S_W-1:0] v);
    logic [MAG_W-1:0] t;
    t = v[S_W-1] ? MAG_W'(-v) : MAG_W'(v);
    return t;
  endfunction

endpackage

[rtl/sfc_if.sv]
// ----------------------------------------------------------------------------
// Sphere frustum cull channels
// Request and result channels with valid and ready.
// ----------------------------------------------------------------------------
interface sfc_req_if;
  import sfc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [IDX_W-1:0]         elem_index;
  logic signed [ELEM_W-1:0] elem_value;
  logic signed [ELEM_W-1:0] center_x;
  logic signed [ELEM_W-1:0] center_y;
  logic signed [ELEM_W-1:0] center_z;
  logic [RAD_W-1:0]         radius;

  modport source (output valid, op, elem_index, elem_value, center_x, center_y,
                  center_z, radius, input ready);
  modport sink (input valid, op, elem_index, elem_value, center_x, center_y,
                center_z, radius, output ready);
endinterface

interface sfc_res_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

[rtl/sfc_front.sv]
// ----------------------------------------------------------------------------
// Sphere frustum cull front end
// Registers each request transfer and classifies it as a write or a test.
// ----------------------------------------------------------------------------
module sfc_front (
  input  logic           clk,
  input  logic           rst,
  sfc_req_if.sink        req,
  output sfc_pkg::item_t item,
  output logic           item_valid,
  input  logic           item_ready
);
  import sfc_pkg::*;

  logic  full;
  item_t hold;

  assign req.ready  = !full || item_ready;
  assign item       = hold;
  assign item_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (req.valid && req.ready) begin
      full <= 1'b1;
    end else if (item_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      hold.op         <= req.op ? OP_TEST : OP_WRITE;
      hold.elem_index <= req.elem_index;
      hold.elem_value <= req.elem_value;
      hold.center_x   <= req.center_x;
      hold.center_y   <= req.center_y;
      hold.center_z   <= req.center_z;
      hold.radius     <= req.radius;
    end
  end
endmodule

[rtl/sfc_fifo.sv]
// ----------------------------------------------------------------------------
// Sphere frustum cull item queue
// Short queue between the front end and the plane test engine.
// ----------------------------------------------------------------------------
module sfc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sfc_pkg::item_t push_item,
  output logic           not_full,
  input  logic           pop,
  output sfc_pkg::item_t pop_item,
  output logic           not_empty
);
  import sfc_pkg::*;

  item_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp;
  logic [FIFO_PTR_W-1:0] rp;
  logic [FIFO_PTR_W:0]   cnt;
  logic                  do_push;
  logic                  do_pop;

  assign not_full  = cnt != (FIFO_PTR_W + 1)'(FIFO_DEPTH);
  assign not_empty = cnt != '0;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= push_item;
    end
  end
endmodule

[rtl/sfc_mul.sv]
// ----------------------------------------------------------------------------
// Sphere frustum cull multiplier
// Unsigned shift and add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sfc_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  sfc_pkg::mul_req_t           mreq,
  output logic                        done,
  output logic [sfc_pkg::PROD_W-1:0]  prod
);
  import sfc_pkg::*;

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    acc;
  logic [PROD_W-1:0]    mc;
  logic [MAG_W-1:0]     mp;

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (mreq.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.start) begin
      acc <= '0;
      mc  <= PROD_W'(mreq.a);
      mp  <= mreq.b;
    end else if (busy) begin
      acc <= acc + (mp[0] ? mc : '0);
      mc  <= mc << 1;
      mp  <= mp >> 1;
    end
  end
endmodule

[rtl/sfc_back.sv]
// ----------------------------------------------------------------------------
// Sphere frustum cull plane test engine
// Holds the matrix, forms each plane and runs the exact cull comparison.
// ----------------------------------------------------------------------------
module sfc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  sfc_pkg::item_t              item,
  input  logic                        item_valid,
  output logic                        item_ready,
  output sfc_pkg::mul_req_t           mreq,
  input  logic                        done,
  input  logic [sfc_pkg::PROD_W-1:0]  prod,
  sfc_res_if.source                   res
);
  import sfc_pkg::*;

  back_state_t state, state_next;
  step_t       step, step_next;
  logic [PLANE_W-1:0] plane, plane_next;

  logic signed [ELEM_W-1:0] mat [MAT_DEPTH];
  logic signed [ELEM_W-1:0] cx, cy, cz;
  logic [RAD_W-1:0]         radius;
  logic [R2_W-1:0]          r2;
  logic signed [COEF_W-1:0] ca, cb, cc;
  logic signed [COEF_W-1:0] coef [4];
  logic [NSUM_W-1:0]        nsum;
  logic signed [S_W-1:0]    s;
  logic signed [S_W-1:0]    s_add;
  logic signed [S_W-1:0]    sprod;
  logic [PROD_W-1:0]        sq;
  logic                     vis;
  logic                     neg;
  logic                     cull;
  logic                     skip;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (plane[0]) begin
        coef[j] = COEF_W'(mat[{2'b11, 2'(j)}]) - COEF_W'(mat[{plane[2:1], 2'(j)}]);
      end else begin
        coef[j] = COEF_W'(mat[{2'b11, 2'(j)}]) + COEF_W'(mat[{plane[2:1], 2'(j)}]);
      end
    end
  end

  always_comb begin
    case (step)
      STEP_AX: neg = ca[COEF_W-1] ^ cx[ELEM_W-1];
      STEP_BY: neg = cb[COEF_W-1] ^ cy[ELEM_W-1];
      STEP_CZ: neg = cc[COEF_W-1] ^ cz[ELEM_W-1];
      default: neg = 1'b0;
    endcase
    sprod = neg ? -$signed(prod[S_W-1:0]) : $signed(prod[S_W-1:0]);
    s_add = s + sprod;
    skip  = (nsum == '0) || !s_add[S_W-1];
    cull  = sq > prod;
  end

  always_comb begin
    mreq.start = state == ST_START;
    case (step)
      STEP_R2: begin
        mreq.a = MAG_W'(radius);
        mreq.b = MAG_W'(radius);
      end
      STEP_AA: begin
        mreq.a = mag(S_W'(ca));
        mreq.b = mag(S_W'(ca));
      end
      STEP_BB: begin
        mreq.a = mag(S_W'(cb));
        mreq.b = mag(S_W'(cb));
      end
      STEP_CC: begin
        mreq.a = mag(S_W'(cc));
        mreq.b = mag(S_W'(cc));
      end
      STEP_AX: begin
        mreq.a = mag(S_W'(ca));
        mreq.b = mag(S_W'(cx));
      end
      STEP_BY: begin
        mreq.a = mag(S_W'(cb));
        mreq.b = mag(S_W'(cy));
      end
      STEP_CZ: begin
        mreq.a = mag(S_W'(cc));
        mreq.b = mag(S_W'(cz));
      end
      STEP_SS: begin
        mreq.a = mag(s);
        mreq.b = mag(s);
      end
      STEP_RN: begin
        mreq.a = MAG_W'(r2);
        mreq.b = MAG_W'(nsum);
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    plane_next = plane;
    item_ready = state == ST_IDLE;
    res.valid  = state == ST_SEND;
    res.visible = vis;
    case (state)
      ST_IDLE: begin
        if (item_valid && item.op == OP_TEST) begin
          step_next  = STEP_R2;
          state_next = ST_START;
        end
      end
      ST_START: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (done) begin
          state_next = ST_START;
          case (step)
            STEP_R2: begin
              plane_next = '0;
              state_next = ST_PLANE;
            end
            STEP_AA: step_next = STEP_BB;
            STEP_BB: step_next = STEP_CC;
            STEP_CC: step_next = STEP_AX;
            STEP_AX: step_next = STEP_BY;
            STEP_BY: step_next = STEP_CZ;
            STEP_CZ: begin
              if (skip) begin
                if (plane == PLANE_W'(PLANE_COUNT - 1)) begin
                  state_next = ST_SEND;
                end else begin
                  plane_next = plane + 1'b1;
                  state_next = ST_PLANE;
                end
              end else begin
                step_next = STEP_SS;
              end
            end
            STEP_SS: step_next = STEP_RN;
            default: begin
              if (cull || plane == PLANE_W'(PLANE_COUNT - 1)) begin
                state_next = ST_SEND;
              end else begin
                plane_next = plane + 1'b1;
                state_next = ST_PLANE;
              end
            end
          endcase
        end
      end
      ST_PLANE: begin
        step_next  = STEP_AA;
        state_next = ST_START;
      end
      ST_SEND: begin
        if (res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_R2;
      plane <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      plane <= plane_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      if (item.op == OP_WRITE) begin
        mat[item.elem_index] <= item.elem_value;
      end else begin
        cx     <= item.center_x;
        cy     <= item.center_y;
        cz     <= item.center_z;
        radius <= item.radius;
        vis    <= 1'b1;
      end
    end
    if (state == ST_PLANE) begin
      ca   <= coef[0];
      cb   <= coef[1];
      cc   <= coef[2];
      nsum <= '0;
      s    <= S_W'(coef[3]) <<< FRAC_BITS;
    end
    if (state == ST_WAIT && done) begin
      case (step)
        STEP_R2: r2 <= prod[R2_W-1:0];
        STEP_AA, STEP_BB, STEP_CC: nsum <= nsum + prod[NSUM_W-1:0];
        STEP_AX, STEP_BY, STEP_CZ: s <= s_add;
        STEP_SS: sq <= prod;
        STEP_RN: begin
          if (cull) begin
            vis <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/sphere_frustum_cull_test.sv]
// ----------------------------------------------------------------------------
// Sphere frustum cull test
// A matrix write leaves the queue as soon as the engine is idle. A test
// runs its plane steps on the one shared 68-step shift and add multiplier.
// One item is worked at a time; the front register and a two-entry queue
// take new transfers meanwhile. Synchronous reset empties the queue and
// idles the engine; the matrix is not cleared.
// ----------------------------------------------------------------------------
module sphere_frustum_cull_test (
  input logic       clk,
  input logic       rst,
  sfc_req_if.sink   req,
  sfc_res_if.source res
);
  import sfc_pkg::*;

  item_t             f_item;
  logic              f_valid;
  logic              f_ready;
  item_t             q_item;
  logic              q_valid;
  logic              q_pop;
  mul_req_t          mreq;
  logic              mdone;
  logic [PROD_W-1:0] mprod;

  sfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  sfc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_item (f_item),
    .not_full  (f_ready),
    .pop       (q_pop),
    .pop_item  (q_item),
    .not_empty (q_valid)
  );

  sfc_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .mreq (mreq),
    .done (mdone),
    .prod (mprod)
  );

  sfc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (q_item),
    .item_valid (q_valid),
    .item_ready (q_pop),
    .mreq       (mreq),
    .done       (mdone),
    .prod       (mprod),
    .res        (res)
  );
endmodule

[rtl/sfc_checker.sv]
// ----------------------------------------------------------------------------
// Sphere frustum cull checker
// Port level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfc_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic visible
);
  `SFC_ASSERT_ALWAYS(a_rst_idle, rst |=> !out_valid, "result valid after reset")
  `SFC_ASSERT(a_hold_valid, out_valid && !out_ready |=> out_valid, "result dropped")
  `SFC_ASSERT(a_hold_data, out_valid && !out_ready |=> $stable(visible), "result changed")
  `SFC_ASSERT(a_one_result, out_valid && out_ready |=> !out_valid, "result repeated")
endmodule

bind sphere_frustum_cull_test sfc_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .visible   (res.visible)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere frustum cull testbench
// Loads view-projection matrices one element at a time and tests bounding
// spheres against the six clip planes. Every visible flag is checked against
// an exact wide-integer predictor, while both channels idle and stall at
// random and the result side is once held off long enough to fill the block.
// ----------------------------------------------------------------------------
module tb;
  import sfc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfc_req_if req ();
  sfc_res_if res ();

  sphere_frustum_cull_test dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .res (res.source)
  );

  always #4 clk = ~clk;

  localparam int WATCHDOG_LIMIT = 80000;
  localparam int HOLD_CYCLES    = 24000;
  localparam int DRAIN_CYCLES   = 200;

  logic signed [ELEM_W-1:0] mat_img [MAT_DEPTH];
  logic                     visible_q [$];
  int                       send_idle_pct = 0;
  int                       recv_stall_pct = 0;
  event                     hold_ev;
  logic                     hold_on;
  int                       idle_count = 0;
  int                       errors = 0;

  function automatic logic predict_visible(logic signed [ELEM_W-1:0] cx,
                                           logic signed [ELEM_W-1:0] cy,
                                           logic signed [ELEM_W-1:0] cz,
                                           logic [RAD_W-1:0] r);
    logic signed [159:0] co [4];
    logic signed [159:0] wc [3];
    logic signed [159:0] r2, n, s;
    int row;
    r2 = $signed({129'd0, r}) * $signed({129'd0, r});
    wc[0] = cx;
    wc[1] = cy;
    wc[2] = cz;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      row = p >> 1;
      for (int j = 0; j < 4; j++) begin
        if (p & 1) co[j] = mat_img[12 + j];
        else co[j] = mat_img[12 + j];
        if (p & 1) co[j] = co[j] - mat_img[row * 4 + j];
        else co[j] = co[j] + mat_img[row * 4 + j];
      end
      n = co[0] * co[0] + co[1] * co[1] + co[2] * co[2];
      if (n == 0) continue;
      s = (co[3] <<< FRAC_BITS) + co[0] * wc[0] + co[1] * wc[1] + co[2] * wc[2];
      if (s >= 0) continue;
      if (s * s > r2 * n) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.op         <= it.op;
    req.elem_index <= it.elem_index;
    req.elem_value <= it.elem_value;
    req.center_x   <= it.center_x;
    req.center_y   <= it.center_y;
    req.center_z   <= it.center_z;
    req.radius     <= it.radius;
    do @(posedge clk); while (!req.ready);
    if (it.op == OP_WRITE) mat_img[it.elem_index] = it.elem_value;
    else visible_q.insert(visible_q.size(),
                          predict_visible(it.center_x, it.center_y,
                                          it.center_z, it.radius));
  endtask

  task automatic write_elem(int idx, logic [ELEM_W-1:0] v);
    item_t it;
    it = '{op: OP_WRITE, elem_index: IDX_W'(idx), elem_value: v,
           center_x: $urandom, center_y: $urandom, center_z: $urandom,
           radius: RAD_W'($urandom)};
    send_item(it);
  endtask

  task automatic test_sphere(logic [ELEM_W-1:0] x, logic [ELEM_W-1:0] y,
                             logic [ELEM_W-1:0] z, logic [RAD_W-1:0] r);
    item_t it;
    it = '{op: OP_TEST, elem_index: IDX_W'($urandom), elem_value: $urandom,
           center_x: x, center_y: y, center_z: z, radius: r};
    send_item(it);
  endtask

  function automatic logic [ELEM_W-1:0] rand_value(int mode);
    case (mode)
      0: return ELEM_W'($signed($urandom_range(8 << FRAC_BITS)) - (4 << FRAC_BITS));
      1: return $urandom;
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] rand_radius();
    case ($urandom_range(3))
      0: return RAD_W'($urandom);
      1: return RAD_W'($urandom_range(4 << FRAC_BITS));
      2: return RAD_W'($urandom_range(1 << FRAC_BITS));
      default: return RAD_W'($urandom_range(255));
    endcase
  endfunction

  task automatic load_matrix(int mode);
    for (int i = 0; i < MAT_DEPTH; i++) write_elem(i, rand_value(mode));
  endtask

  task automatic test_identity_and_extremes();
    for (int i = 0; i < MAT_DEPTH; i++)
      write_elem(i, (i % 5 == 0) ? (1 << FRAC_BITS) : 0);
    test_sphere(0, 0, 0, 0);
    test_sphere(32'h0002_0000, 0, 0, 0);
    test_sphere(32'h0002_0000, 0, 0, 31'h0002_0000);
    test_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
    test_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    write_elem(0, 32'h8000_0000);
    write_elem(15, 32'h7fff_ffff);
    test_sphere(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    test_sphere(32'h8000_0000, 0, 32'hffff_ffff, 31'h7fff_ffff);
  endtask

  task automatic test_zero_length_planes();
    for (int i = 0; i < MAT_DEPTH; i++) write_elem(i, 0);
    test_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
    write_elem(15, 32'hfff0_0000);
    test_sphere(0, 0, 0, 31'h7fff_ffff);
    write_elem(0, 32'h0001_0000);
    write_elem(12, 32'h0001_0000);
    test_sphere(32'h0010_0000, 0, 0, 0);
  endtask

  task automatic run_random(int n_items, int idle, int stall);
    int sent;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0, 1, 2: begin
          load_matrix($urandom_range(2));
          sent += MAT_DEPTH;
        end
        3, 4: begin
          write_elem($urandom_range(15), rand_value($urandom_range(2)));
          sent++;
        end
        default: begin
          if ($urandom_range(1))
            test_sphere(rand_value(0), rand_value(0), rand_value(0), rand_radius());
          else
            test_sphere(rand_value(1), rand_value(1), rand_value($urandom_range(2)),
                        rand_radius());
          sent++;
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    -> hold_ev;
    for (int i = 0; i < 6; i++)
      test_sphere(rand_value(0), rand_value(0), rand_value(0), rand_radius());
  endtask

  always begin
    hold_on <= 1'b0;
    @(hold_ev);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
  end

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_on) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req.valid && req.ready) || (res.valid && res.ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
      if (res.valid && res.ready) begin
        if (visible_q.size() == 0) begin
          $error("unexpected result: visible=%0b", res.visible);
          errors++;
        end else begin
          logic exp_vis;
          exp_vis = visible_q.pop_front();
          if (res.visible !== exp_vis) begin
            $error("visible mismatch: expected %0b, actual %0b", exp_vis, res.visible);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    req.valid = 1'b0;
    req.op = OP_WRITE;
    req.elem_index = '0;
    req.elem_value = '0;
    req.center_x = '0;
    req.center_y = '0;
    req.center_z = '0;
    req.radius = '0;
    for (int i = 0; i < MAT_DEPTH; i++) mat_img[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity_and_extremes();
    test_zero_length_planes();
    run_random(300, 0, 0);
    run_random(250, 72, 0);
    run_random(250, 0, 72);
    run_random(250, 34, 34);
    test_backpressure();
    run_random(50, 0, 0);
    req.valid <= 1'b0;
    wait (visible_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && visible_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/sfc_pkg.sv
rtl/sfc_if.sv
rtl/sfc_front.sv
rtl/sfc_fifo.sv
rtl/sfc_mul.sv
rtl/sfc_back.sv
rtl/sphere_frustum_cull_test.sv
rtl/sfc_checker.sv
tb/tb.sv
